// ----- src/fct_pkg.sv -----
// fct_pkg: types and constants shared by the frustum cull test block.
// Plane register layout, object item layout and test kind codes.
// No dependencies.
`default_nettype none

package fct_pkg;

  // Test kind carried with each item
  typedef enum logic [1:0] {
    ACT_POINT  = 2'd0,
    ACT_CUBE   = 2'd1,
    ACT_SPHERE = 2'd2,
    ACT_BOX    = 2'd3
  } action_e;

  localparam int unsigned COORD_W   = 16;  // signed Q7.8
  localparam int unsigned EXTENT_W  = 15;  // unsigned Q7.8
  localparam int unsigned COEF_W    = 16;  // a, b, c signed Q1.14; d signed Q7.8
  localparam int unsigned PLANE_W   = 4 * COEF_W;
  localparam int unsigned CFG_IDX_W = 3;   // covers up to eight planes
  localparam int unsigned PROD_W    = COORD_W + COEF_W;       // signed product
  localparam int unsigned MAG_W     = COEF_W + EXTENT_W;      // unsigned |coef| * extent
  localparam int unsigned MARGIN_W  = MAG_W + 3;
  localparam int unsigned SUM_W     = 36;  // distance plus margin, exact
  localparam int unsigned D_SHIFT   = 14;  // align Q7.8 d to 22 fraction bits

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] d;
  } plane_t;

  typedef struct packed {
    action_e                   action;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [EXTENT_W-1:0]       ex;
    logic [EXTENT_W-1:0]       ey;
    logic [EXTENT_W-1:0]       ez;
  } obj_t;

endpackage

`default_nettype wire

// ----- src/fct_plane.sv -----
// fct_plane: tests one object against one plane, purely combinational.
// The box and cube tests use the farthest corner: center distance plus
// |a|*ex + |b|*ey + |c|*ez. Depends on fct_pkg.
`default_nettype none

module fct_plane
  import fct_pkg::*;
(
  input  plane_t plane_i,
  input  obj_t   obj_i,
  output logic   pass_o
);

  logic signed [PROD_W-1:0]  px, py, pz;
  logic [COEF_W-1:0]         abs_a, abs_b, abs_c;
  logic [EXTENT_W-1:0]       ey_sel, ez_sel;
  logic [MAG_W-1:0]          mx, my, mz;
  logic [MARGIN_W-1:0]       margin;
  logic signed [SUM_W-1:0]   center_dist;
  logic signed [SUM_W-1:0]   total;

  always_comb begin
    px = PROD_W'(plane_i.a) * PROD_W'(obj_i.cx);
    py = PROD_W'(plane_i.b) * PROD_W'(obj_i.cy);
    pz = PROD_W'(plane_i.c) * PROD_W'(obj_i.cz);

    // magnitude of -32768 is 32768, which fits the unsigned width
    abs_a = plane_i.a[COEF_W-1] ? COEF_W'(-plane_i.a) : COEF_W'(plane_i.a);
    abs_b = plane_i.b[COEF_W-1] ? COEF_W'(-plane_i.b) : COEF_W'(plane_i.b);
    abs_c = plane_i.c[COEF_W-1] ? COEF_W'(-plane_i.c) : COEF_W'(plane_i.c);

    // cube uses the single extent on every axis
    ey_sel = (obj_i.action == ACT_CUBE) ? obj_i.ex : obj_i.ey;
    ez_sel = (obj_i.action == ACT_CUBE) ? obj_i.ex : obj_i.ez;

    mx = MAG_W'(abs_a) * MAG_W'(obj_i.ex);
    my = MAG_W'(abs_b) * MAG_W'(ey_sel);
    mz = MAG_W'(abs_c) * MAG_W'(ez_sel);

    unique case (obj_i.action)
      ACT_POINT:  margin = '0;
      ACT_SPHERE: margin = MARGIN_W'(obj_i.ex) << D_SHIFT;
      ACT_CUBE,
      ACT_BOX:    margin = MARGIN_W'(mx) + MARGIN_W'(my) + MARGIN_W'(mz);
      default:    margin = '0;
    endcase

    center_dist = SUM_W'(px) + SUM_W'(py) + SUM_W'(pz)
                + (SUM_W'(plane_i.d) <<< D_SHIFT);
    total = center_dist + $signed(SUM_W'(margin));
    pass_o = ~total[SUM_W-1];
  end

endmodule

`default_nettype wire

// ----- src/frustum_cull_test_core.sv -----
// frustum_cull_test_core: six-plane view frustum culling test, top level.
// Depends on fct_pkg and fct_plane.
//
// One object item is taken on every clock where start_i is high; busy_o
// stays low, so items may stream back to back. Each item yields exactly one
// result, registered first in the input register and then in the result
// register around the per-plane dot product units, which test all planes
// in parallel. done_o pulses for one cycle with visible_o. The receiver
// cannot stall results; they must be captured when done_o is high.
// Plane registers are written through the cfg port, which is always ready;
// writes to an index past the last plane are dropped. Write planes only
// while no item is in flight. Reset clears all planes to zero, which makes
// every object visible.
`default_nettype none

module frustum_cull_test_core
  import fct_pkg::*;
#(
  parameter int unsigned PLANE_COUNT = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [1:0]                 action_i,
  input  logic signed [COORD_W-1:0]  center_x_i,
  input  logic signed [COORD_W-1:0]  center_y_i,
  input  logic signed [COORD_W-1:0]  center_z_i,
  input  logic [EXTENT_W-1:0]        extent_x_i,
  input  logic [EXTENT_W-1:0]        extent_y_i,
  input  logic [EXTENT_W-1:0]        extent_z_i,
  output logic                       done_o,
  output logic                       visible_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [PLANE_W-1:0]         cfg_data_i
);

  plane_t                 plane_q [PLANE_COUNT];
  logic [PLANE_COUNT-1:0] pass;

  logic vld_q;
  obj_t obj_q;
  logic done_q, visible_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // plane registers
  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_plane
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        plane_q[i] <= '0;
      end else if (cfg_valid_i && (cfg_index_i == CFG_IDX_W'(i))) begin
        plane_q[i] <= plane_t'(cfg_data_i);
      end
    end

    fct_plane u_plane (
      .plane_i (plane_q[i]),
      .obj_i   (obj_q),
      .pass_o  (pass[i])
    );
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      obj_q <= '{action: action_e'(action_i),
                 cx: center_x_i, cy: center_y_i, cz: center_z_i,
                 ex: extent_x_i, ey: extent_y_i, ez: extent_z_i};
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      visible_q <= &pass;
    end
  end

  assign done_o    = done_q;
  assign visible_o = visible_q;

endmodule

`default_nettype wire

// ----- src/fct_checker.sv -----
// fct_checker: port-level checks for frustum_cull_test_core, bound to it.
// Sees the top-level ports only. Depends on fct_pkg.
`default_nettype none

module fct_checker
  import fct_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic visible_o,
  input logic cfg_valid_i,
  input logic cfg_ready_o
);

  // every taken item gets its result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("item taken without result two cycles later");

  // no result without a matching taken item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without a matching item");

  // a result carries a defined value
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown(visible_o))
    else $error("visible_o unknown on a result");

  // a config write held off while items flow would be lost
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write stalled");

endmodule

bind frustum_cull_test_core fct_checker u_fct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .visible_o   (visible_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire
